### hw/rtl/rn_pkg.sv
// ----------------------------------------------------------------------------
// rn_pkg: shared types and constants of the rank normalizer
// Field widths, the list descriptor handed from the front to the back, status
// groups, and the state encoding of the rank engine.
// ----------------------------------------------------------------------------
package rn_pkg;

	// Fixed field widths of the stream payloads.
	localparam int VALUE_W     = 32;
	localparam int RANK_W      = 6;
	localparam int OUT_TDATA_W = 8;

	// Largest supported list length and the width of a count up to it.
	localparam int ELEMS_LIMIT = 64;
	localparam int CNT_W       = 7;

	// One closed list waiting for ranking.
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} job_t;

	// Fill status of the list queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Status of the rank engine toward the front.
	typedef struct packed {
		logic active;
		logic done;
		logic bank;
	} back_stat_t;

	// Rank engine sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FETCH,
		BK_CAPT,
		BK_SWEEP,
		BK_LAST,
		BK_EMIT
	} back_state_t;

endpackage

### hw/rtl/rank_normalizer_top.sv
// After the closing transfer the list passes through the queue; the engine then fetches each
// element, sweeps the list through the single read port of the element store and emits the
// rank through the output register, one element after another.
// Input takes one value per cycle while the store bank being filled is free.
// Reset (arst_n low, asynchronous) empties both banks, the queue and the output register.
// ----------------------------------------------------------------------------
// rank_normalizer_top: rank transform of a list of signed values
// Collects a list, then returns each element's rank in ascending sorted order,
// in arrival order, with the last result marked and an overflow flag.
// ----------------------------------------------------------------------------
module rank_normalizer_top #(
	parameter int MAX_ELEMS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rn_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value (signed)
	input  logic                            s_tlast,   // last
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rn_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [5:0] rank, [7:6] zero
	output logic                            m_tlast,   // end_of_list
	output logic                            m_tuser    // [0] overflow
);

	localparam int AW = $clog2(MAX_ELEMS) + 1;

	rn_pkg::back_stat_t         back_stat;
	rn_pkg::q_stat_t            q_stat;
	rn_pkg::job_t               push_job;
	rn_pkg::job_t               head;
	logic                       job_push;
	logic                       job_pop;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [rn_pkg::VALUE_W-1:0] wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [rn_pkg::VALUE_W-1:0] rd_data;

	// Input side.
	rn_front #(
		.MAX_ELEMS (MAX_ELEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.back_stat (back_stat),
		.job_push  (job_push),
		.job       (push_job),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Element store, two banks, each MAX_ELEMS rounded up to a power of two.
	rn_ram #(
		.WIDTH (rn_pkg::VALUE_W),
		.DEPTH (1 << AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Closed lists waiting for the engine.
	rn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Rank engine and output register.
	rn_back #(
		.MAX_ELEMS (MAX_ELEMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.job_pop   (job_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.back_stat (back_stat)
	);

	// A list is never handed over into a full queue.
	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_stat.full)
		else $error("list queue overflow");

	// The engine never takes a list from an empty queue.
	a_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !q_stat.empty)
		else $error("list queue underflow");

	// Input stalls only while some list is queued or being ranked.
	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (!q_stat.empty || back_stat.active))
		else $error("input stalled with no list in flight");

	// Finishing a list returns the engine to idle.
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.done |=> !back_stat.active)
		else $error("engine still active after finishing a list");

endmodule

### hw/rtl/rn_ram.sv
// ----------------------------------------------------------------------------
// rn_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/rn_front.sv
// ----------------------------------------------------------------------------
// rn_front: input side of the rank normalizer
// Writes arriving values into the free bank of the element store, counts them,
// notes dropped values and hands a closed list to the queue.
// ----------------------------------------------------------------------------
module rn_front #(
	parameter int MAX_ELEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rn_pkg::VALUE_W-1:0]  s_tdata,
	input  logic                        s_tlast,
	input  rn_pkg::back_stat_t          back_stat,
	output logic                        job_push,
	output rn_pkg::job_t                job,
	output logic                        wr_en,
	output logic [$clog2(MAX_ELEMS):0]  wr_addr,
	output logic [rn_pkg::VALUE_W-1:0]  wr_data
);

	localparam int IDX_W = $clog2(MAX_ELEMS);
	localparam int CW    = $clog2(MAX_ELEMS + 1);
	localparam int JW    = rn_pkg::CNT_W;

	logic          bank_q;
	logic [CW-1:0] wcnt_q;
	logic          drop_q;
	logic [1:0]    busy_q;
	logic          accept;
	logic          room;
	logic [CW-1:0] cnt_next;
	logic          drop_next;

	// A bank is not writable from hand-over until its list has been fully ranked.
	assign s_tready = !busy_q[bank_q];
	assign accept   = s_tvalid && s_tready;
	assign room     = wcnt_q < CW'(MAX_ELEMS);

	// Store write for values that still fit.
	assign wr_en   = accept && room;
	assign wr_addr = {bank_q, wcnt_q[IDX_W-1:0]};
	assign wr_data = s_tdata;

	assign cnt_next  = room ? wcnt_q + 1'b1 : wcnt_q;
	assign drop_next = drop_q || !room;

	// Closing transfer hands the list over.
	assign job_push    = accept && s_tlast;
	assign job.bank    = bank_q;
	assign job.count   = JW'(cnt_next);
	assign job.dropped = drop_next;

	// Fill counter, drop flag and bank toggle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			wcnt_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				bank_q <= !bank_q;
				wcnt_q <= '0;
				drop_q <= 1'b0;
			end else begin
				wcnt_q <= cnt_next;
				drop_q <= drop_next;
			end
		end
	end

	// Bank occupancy: set on hand-over, cleared when the engine finishes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'b00;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (job_push && (bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (back_stat.done && (back_stat.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

### hw/rtl/rn_queue.sv
// ----------------------------------------------------------------------------
// rn_queue: two-entry list queue
// Holds closed list descriptors between the input side and the rank engine.
// ----------------------------------------------------------------------------
module rn_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rn_pkg::job_t     push_job,
	input  logic             pop,
	output rn_pkg::job_t     head,
	output rn_pkg::q_stat_t  stat
);

	rn_pkg::job_t mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign head       = mem_q[rptr_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/rn_back.sv
// ----------------------------------------------------------------------------
// rn_back: rank engine of the rank normalizer
// For each stored element in arrival order, sweeps the whole list through the
// store read port, counts values less than or equal to it and emits the rank.
// ----------------------------------------------------------------------------
module rn_back #(
	parameter int MAX_ELEMS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rn_pkg::job_t                    head,
	input  rn_pkg::q_stat_t                 q_stat,
	output logic                            job_pop,
	output logic                            rd_en,
	output logic [$clog2(MAX_ELEMS):0]      rd_addr,
	input  logic [rn_pkg::VALUE_W-1:0]      rd_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rn_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                            m_tlast,
	output logic                            m_tuser,
	output rn_pkg::back_stat_t              back_stat
);

	localparam int IDX_W = $clog2(MAX_ELEMS);
	localparam int CW    = $clog2(MAX_ELEMS + 1);
	localparam int RW    = rn_pkg::RANK_W;
	localparam int PAD_W = rn_pkg::OUT_TDATA_W - rn_pkg::RANK_W;

	rn_pkg::back_state_t state_q;
	rn_pkg::back_state_t state_d;

	logic                       bank_q;
	logic [CW-1:0]              n_q;
	logic                       drop_q;
	logic [IDX_W-1:0]           i_q;
	logic [IDX_W-1:0]           k_q;
	logic [CW-1:0]              le_q;
	logic                       cmp_q;
	logic [rn_pkg::VALUE_W-1:0] v_q;
	logic                       out_vld_q;
	logic [RW-1:0]              rank_q;
	logic                       last_q;
	logic                       ovf_q;

	logic k_last;
	logic i_last;
	logic hit;
	logic slot_free;
	logic load_out;
	logic done;

	assign k_last    = CW'(k_q) == (n_q - 1'b1);
	assign i_last    = CW'(i_q) == (n_q - 1'b1);
	assign hit       = $signed(rd_data) <= $signed(v_q);
	assign slot_free = !out_vld_q || m_tready;

	// Sequencer: next state and strobes.
	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = {bank_q, i_q};
		load_out = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			rn_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					job_pop = 1'b1;
					state_d = rn_pkg::BK_FETCH;
				end
			end
			rn_pkg::BK_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = {bank_q, i_q};
				state_d = rn_pkg::BK_CAPT;
			end
			rn_pkg::BK_CAPT: begin
				state_d = rn_pkg::BK_SWEEP;
			end
			rn_pkg::BK_SWEEP: begin
				rd_en   = 1'b1;
				rd_addr = {bank_q, k_q};
				if (k_last) begin
					state_d = rn_pkg::BK_LAST;
				end
			end
			rn_pkg::BK_LAST: begin
				state_d = rn_pkg::BK_EMIT;
			end
			rn_pkg::BK_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (i_last) begin
						done    = 1'b1;
						state_d = rn_pkg::BK_IDLE;
					end else begin
						state_d = rn_pkg::BK_FETCH;
					end
				end
			end
			default: begin
				state_d = rn_pkg::BK_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rn_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// List descriptor, element under test and the compare sweep.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			bank_q <= head.bank;
			n_q    <= CW'(head.count);
			drop_q <= head.dropped;
			i_q    <= '0;
		end
		if (state_q == rn_pkg::BK_CAPT) begin
			v_q   <= rd_data;
			k_q   <= '0;
			le_q  <= '0;
			cmp_q <= 1'b0;
		end
		if (state_q == rn_pkg::BK_SWEEP) begin
			k_q   <= k_q + 1'b1;
			cmp_q <= 1'b1;
			if (cmp_q && hit) begin
				le_q <= le_q + 1'b1;
			end
		end
		if (state_q == rn_pkg::BK_LAST && hit) begin
			le_q <= le_q + 1'b1;
		end
		if (load_out) begin
			rank_q <= RW'(le_q - 1'b1);
			last_q <= i_last;
			ovf_q  <= drop_q;
			if (!i_last) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, rank_q};
	assign m_tlast  = last_q;
	assign m_tuser  = ovf_q;

	assign back_stat.active = state_q != rn_pkg::BK_IDLE;
	assign back_stat.done   = done;
	assign back_stat.bank   = bank_q;

endmodule
